### hdl/pcr_pkg.sv
// Shared types and constants for the pre-trigger capture ring.
package pcr_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int RING_DEPTH_DEF = 128;
	localparam int REG_W          = 8;
	localparam int WORD_W         = 2 * SAMPLE_BITS;

	localparam logic [REG_W-1:0] PRE_WORDS_RESET  = 8'd40;
	localparam logic [REG_W-1:0] POST_WORDS_RESET = 8'd80;

	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_TRIGGER = 2'd1,
		KIND_READ    = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_ARMED   = 2'd0,
		MODE_CAPTURE = 2'd1,
		MODE_READOUT = 2'd2
	} mode_t;

	typedef enum logic {
		REG_PRE_WORDS  = 1'b0,
		REG_POST_WORDS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		kind_t                  kind;
		logic [SAMPLE_BITS-1:0] first_sample;
		logic [SAMPLE_BITS-1:0] second_sample;
	} item_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] early_sample;
		logic [SAMPLE_BITS-1:0] late_sample;
		logic                   last_word;
		logic                   status;
	} result_t;

endpackage

### hdl/pcr_ring.sv
// Sample pair memory with registered read and a fill count for never-written words.
module pcr_ring
	import pcr_pkg::*;
#(
	parameter int DEPTH = RING_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int LW    = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata,
	output logic              rhit
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic              rhit_q;
	logic [LW-1:0]     fill_q;

	// writes always start at zero after reset or re-arm, so written words form a prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (we && (LW'(waddr) == fill_q)) begin
			fill_q <= fill_q + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
			rhit_q  <= (LW'(raddr) < fill_q);
		end
	end

	assign rdata = rdata_q;
	assign rhit  = rhit_q;

endmodule

### hdl/pretrigger_capture_ring.sv
// Top level of the pre-trigger capture ring.
// Takes one item per clock with no stall (busy stays low); a read item gives its result on
// the cycle after its transfer, set by the ring memory's registered read port, and the
// result must be taken then. Sample, trigger and kind 3 items give no result; a read before
// the capture has stopped returns zeros with status set. Ring words never written since reset
// read as zero through a fill count, so no clearing pass follows reset.
module pretrigger_capture_ring
	import pcr_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            item,
	output logic             result_valid,
	output result_t          result,
	input  logic             cfg_we,
	input  reg_idx_t         cfg_index,
	input  logic [REG_W-1:0] cfg_data
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int LW = $clog2(RING_DEPTH + 1);
	localparam int SW = ((LW > REG_W + 1) ? LW : (REG_W + 1)) + 1;

	localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);

	logic [REG_W-1:0] pre_words_q;
	logic [REG_W-1:0] post_words_q;
	mode_t            mode_q;
	mode_t            mode_d;
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    trig_q;
	logic [REG_W-1:0] atc_q;
	logic [AW-1:0]    rc_q;

	logic             accept;
	logic             do_write;
	logic             do_read;
	logic             do_trigger;
	logic             cap_done;

	logic [REG_W-1:0] post_eff;
	logic [SW-1:0]    pre_clip;
	logic [SW-1:0]    len_sum;
	logic [SW-1:0]    win_len;
	logic [SW-1:0]    start_sum;
	logic [SW-1:0]    win_base;
	logic [SW-1:0]    idx_sum;
	logic [AW-1:0]    rd_idx;
	logic             last;
	logic [AW-1:0]    wp_inc;

	logic             res_valid_s1;
	logic             res_status_s1;
	logic             res_last_s1;
	logic [WORD_W-1:0] ring_rdata;
	logic             ring_hit;
	logic             zero_out;

	assign busy   = 1'b0;
	assign accept = start;

	// window arithmetic
	assign post_eff  = (post_words_q == '0) ? REG_W'(1) : post_words_q;
	assign pre_clip  = (SW'(pre_words_q) > DEPTH_S) ? DEPTH_S : SW'(pre_words_q);
	assign len_sum   = pre_clip + SW'(post_eff);
	assign win_len   = (len_sum > DEPTH_S) ? DEPTH_S : len_sum;
	assign start_sum = SW'(trig_q) + DEPTH_S - pre_clip;
	assign win_base  = (start_sum >= DEPTH_S) ? (start_sum - DEPTH_S) : start_sum;
	assign idx_sum   = win_base + SW'(rc_q);
	assign rd_idx    = (idx_sum >= DEPTH_S) ? AW'(idx_sum - DEPTH_S) : AW'(idx_sum);
	assign last      = (SW'(rc_q) + SW'(1)) >= win_len;
	assign wp_inc    = (SW'(wp_q) == DEPTH_S - SW'(1)) ? '0 : (wp_q + AW'(1));
	assign cap_done  = ((REG_W + 1)'(atc_q) + (REG_W + 1)'(1)) >= (REG_W + 1)'(post_eff);

	// next state
	always_comb begin
		mode_d = mode_q;
		if (accept) begin
			case (mode_q)
				MODE_ARMED: begin
					if (item.kind == KIND_TRIGGER) mode_d = MODE_CAPTURE;
				end
				MODE_CAPTURE: begin
					if (item.kind == KIND_SAMPLE && cap_done) mode_d = MODE_READOUT;
				end
				MODE_READOUT: begin
					if (item.kind == KIND_READ && last) mode_d = MODE_ARMED;
				end
				default: begin
					mode_d = MODE_ARMED;
				end
			endcase
		end
	end

	// per-item actions
	always_comb begin
		do_write   = 1'b0;
		do_read    = 1'b0;
		do_trigger = 1'b0;
		if (accept) begin
			case (item.kind)
				KIND_SAMPLE:  do_write   = (mode_q != MODE_READOUT);
				KIND_TRIGGER: do_trigger = (mode_q == MODE_ARMED);
				KIND_READ:    do_read    = (mode_q == MODE_READOUT);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_words_q  <= PRE_WORDS_RESET;
			post_words_q <= POST_WORDS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRE_WORDS:  pre_words_q  <= cfg_data;
				REG_POST_WORDS: post_words_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ARMED;
			wp_q   <= '0;
			trig_q <= '0;
			atc_q  <= '0;
			rc_q   <= '0;
		end else begin
			mode_q <= mode_d;
			if (do_write) begin
				wp_q <= wp_inc;
				if (mode_q == MODE_CAPTURE) begin
					atc_q <= atc_q + REG_W'(1);
					if (cap_done) rc_q <= '0;
				end
			end
			if (do_trigger) begin
				trig_q <= wp_q;
				atc_q  <= '0;
			end
			if (do_read) begin
				if (last) begin
					wp_q <= '0;
					rc_q <= '0;
				end else begin
					rc_q <= rc_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else begin
			res_valid_s1 <= accept && (item.kind == KIND_READ);
		end
	end

	always_ff @(posedge clk) begin
		res_status_s1 <= (mode_q != MODE_READOUT);
		res_last_s1   <= (mode_q == MODE_READOUT) && last;
	end

	pcr_ring #(
		.DEPTH (RING_DEPTH),
		.AW    (AW),
		.LW    (LW)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (do_write),
		.waddr  (wp_q),
		.wdata  ({item.second_sample, item.first_sample}),
		.re     (do_read),
		.raddr  (rd_idx),
		.rdata  (ring_rdata),
		.rhit   (ring_hit)
	);

	// not-ready reads and never-written words both give zero samples
	assign zero_out = res_status_s1 || !ring_hit;

	assign result_valid        = res_valid_s1;
	assign result.early_sample = zero_out ? '0 : ring_rdata[SAMPLE_BITS-1:0];
	assign result.late_sample  = zero_out ? '0 : ring_rdata[WORD_W-1:SAMPLE_BITS];
	assign result.last_word    = res_last_s1;
	assign result.status       = res_status_s1;

endmodule

### tb/pretrigger_capture_ring_checker.sv
// Checker for the capture ring: tracks its state from the ports and checks each read result.
`timescale 1ns / 1ps
module pretrigger_capture_ring_checker
	import pcr_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  item_t            item,
	input  logic             result_valid,
	input  result_t          result,
	input  logic             cfg_we,
	input  reg_idx_t         cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	output int               errors,
	output int               outstanding,
	output int               words_checked,
	output int               windows_done,
	output int               early_reads
);

	logic [WORD_W-1:0] ring_copy [RING_DEPTH];
	int unsigned       wr_ptr;
	int unsigned       trig_ptr;
	int unsigned       post_seen;
	int unsigned       words_read;
	mode_t             mode;
	logic [REG_W-1:0]  pre_reg;
	logic [REG_W-1:0]  post_reg;
	result_t           expected_words [$];

	function automatic int unsigned pre_clipped();
		return (pre_reg > RING_DEPTH) ? RING_DEPTH : pre_reg;
	endfunction

	function automatic int unsigned post_needed();
		return (post_reg == 0) ? 1 : post_reg;
	endfunction

	// Updates the ring copy for one transfer and queues the read result it causes.
	task automatic predict_ring_step(input item_t it);
		result_t     r;
		int unsigned win_len;
		int unsigned slot;
		r = '0;
		case (it.kind)
			KIND_SAMPLE: begin
				if (mode != MODE_READOUT) begin
					ring_copy[wr_ptr] = {it.second_sample, it.first_sample};
					wr_ptr = (wr_ptr + 1) % RING_DEPTH;
					if (mode == MODE_CAPTURE) begin
						post_seen++;
						if (post_seen >= post_needed()) begin
							mode = MODE_READOUT;
							words_read = 0;
						end
					end
				end
			end
			KIND_TRIGGER: begin
				if (mode == MODE_ARMED) begin
					trig_ptr = wr_ptr;
					post_seen = 0;
					mode = MODE_CAPTURE;
				end
			end
			KIND_READ: begin
				if (mode != MODE_READOUT) begin
					r.status = 1'b1;
				end else begin
					win_len = pre_clipped() + post_needed();
					if (win_len > RING_DEPTH)
						win_len = RING_DEPTH;
					slot = (trig_ptr + RING_DEPTH - pre_clipped() + words_read) % RING_DEPTH;
					r.early_sample = ring_copy[slot][SAMPLE_BITS-1:0];
					r.late_sample = ring_copy[slot][WORD_W-1:SAMPLE_BITS];
					r.last_word = (words_read + 1 >= win_len);
					if (r.last_word) begin
						mode = MODE_ARMED;
						wr_ptr = 0;
						words_read = 0;
					end else begin
						words_read++;
					end
				end
				expected_words.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_word;
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++)
				ring_copy[i] = '0;
			wr_ptr = 0;
			trig_ptr = 0;
			post_seen = 0;
			words_read = 0;
			mode = MODE_ARMED;
			pre_reg = PRE_WORDS_RESET;
			post_reg = POST_WORDS_RESET;
			expected_words.delete();
			errors = 0;
			words_checked = 0;
			windows_done = 0;
			early_reads = 0;
			outstanding <= 0;
		end else begin
			if (result_valid) begin
				if (expected_words.size() == 0) begin
					if (errors < 10)
						$display("%0t: read result with no read pending: %p", $time, result);
					errors++;
				end else begin
					exp_word = expected_words.pop_front();
					if (result.early_sample !== exp_word.early_sample ||
					    result.late_sample !== exp_word.late_sample ||
					    result.last_word !== exp_word.last_word ||
					    result.status !== exp_word.status) begin
						if (errors < 10)
							$display("%0t: read mismatch, expected early %h late %h last %b status %b, got early %h late %h last %b status %b",
								$time, exp_word.early_sample, exp_word.late_sample,
								exp_word.last_word, exp_word.status, result.early_sample,
								result.late_sample, result.last_word, result.status);
						errors++;
					end
					words_checked++;
					if (exp_word.status)
						early_reads++;
					else if (exp_word.last_word)
						windows_done++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PRE_WORDS:  pre_reg = cfg_data;
					REG_POST_WORDS: post_reg = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				predict_ring_step(item);
			outstanding <= expected_words.size();
		end
	end

endmodule

### tb/pretrigger_capture_ring_tb.sv
// Testbench top for the capture ring: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
module pretrigger_capture_ring_tb
	import pcr_pkg::*;
();

	localparam int RANDOM_ITEMS   = 400;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 1000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	item_t            item = '0;
	logic             result_valid;
	result_t          result;
	logic             cfg_we = 1'b0;
	reg_idx_t         cfg_index = REG_PRE_WORDS;
	logic [REG_W-1:0] cfg_data = '0;

	int errors;
	int outstanding;
	int words_checked;
	int windows_done;
	int early_reads;

	int               idle_pct = 33;
	int               sent_items = 0;
	int               quiet_cycles = 0;
	logic [REG_W-1:0] cur_pre = PRE_WORDS_RESET;
	logic [REG_W-1:0] cur_post = POST_WORDS_RESET;

	always #2 clk = ~clk;

	pretrigger_capture_ring i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pretrigger_capture_ring_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_valid  (result_valid),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.outstanding   (outstanding),
		.words_checked (words_checked),
		.windows_done  (windows_done),
		.early_reads   (early_reads)
	);

	// Window length the ring will read out for a given register setting.
	function automatic int window_words(input int pre, input int post);
		int pc;
		int qc;
		pc = (pre > RING_DEPTH_DEF) ? RING_DEPTH_DEF : pre;
		qc = (post == 0) ? 1 : post;
		return (pc + qc > RING_DEPTH_DEF) ? RING_DEPTH_DEF : pc + qc;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		return SAMPLE_BITS'($urandom_range(4095));
	endfunction

	task automatic send_item(input kind_t k, input logic [SAMPLE_BITS-1:0] a,
	                         input logic [SAMPLE_BITS-1:0] b);
		start <= 1'b1;
		item <= '{kind: k, first_sample: a, second_sample: b};
		do @(posedge clk); while (busy);
		sent_items++;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_sample();
		send_item(KIND_SAMPLE, rand_sample(), rand_sample());
	endtask

	// Occasional items that the ring ignores or answers with a not-ready word.
	task automatic maybe_noise(input mode_t phase);
		kind_t pick;
		if ($urandom_range(7) == 0) begin
			case (phase)
				MODE_ARMED:   pick = $urandom_range(1) ? KIND_READ : KIND_NONE;
				MODE_CAPTURE: begin
					case ($urandom_range(2))
						0:       pick = KIND_TRIGGER;
						1:       pick = KIND_READ;
						default: pick = KIND_NONE;
					endcase
				end
				default: begin
					case ($urandom_range(2))
						0:       pick = KIND_TRIGGER;
						1:       pick = KIND_SAMPLE;
						default: pick = KIND_NONE;
					endcase
				end
			endcase
			send_item(pick, rand_sample(), rand_sample());
		end
	endtask

	// Hold off until every read result is back, then let the pipeline settle.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [REG_W-1:0] pre, input logic [REG_W-1:0] post);
		cfg_we <= 1'b1;
		cfg_index <= REG_PRE_WORDS;
		cfg_data <= pre;
		@(posedge clk);
		cfg_index <= REG_POST_WORDS;
		cfg_data <= post;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_pre = pre;
		cur_post = post;
	endtask

	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int wl;
		int cut;
		int n_pre;
		int ep;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: not-ready read, unused kind, sample extremes, ignored triggers,
		// capture stop, dropped sample, and a window that wraps below slot zero
		// into never-written words
		send_item(KIND_READ, '0, '0);
		send_item(KIND_NONE, 12'hfff, 12'hfff);
		drain();
		set_config(8'd6, 8'd2);
		send_item(KIND_SAMPLE, 12'h000, 12'h000);
		send_item(KIND_SAMPLE, 12'hfff, 12'hfff);
		send_item(KIND_SAMPLE, 12'haaa, 12'h555);
		send_item(KIND_SAMPLE, 12'h555, 12'haaa);
		send_item(KIND_TRIGGER, '0, '0);
		send_item(KIND_TRIGGER, 12'hfff, 12'hfff);
		send_item(KIND_READ, '0, '0);
		send_sample();
		send_item(KIND_SAMPLE, 12'hfff, 12'h000);
		send_item(KIND_SAMPLE, 12'h123, 12'h456);
		send_item(KIND_TRIGGER, '0, '0);
		repeat (8) send_item(KIND_READ, '0, '0);
		send_item(KIND_READ, '0, '0);

		// capture cycles: the first random, then the extreme settings, then random
		ep = 0;
		while (sent_items < RANDOM_ITEMS) begin
			idle_pct = (sent_items < RANDOM_ITEMS / 3) ? 33 :
			           (sent_items < 2 * RANDOM_ITEMS / 3) ? 52 : 0;
			if (ep <= 3 || $urandom_range(2) == 0) begin
				drain();
				case (ep)
					1:       set_config(8'd255, 8'd0);
					2:       set_config(8'd128, 8'd3);
					3:       set_config(8'd0, 8'd255);
					default: begin
						if ($urandom_range(7) == 0)
							set_config(REG_W'($urandom_range(255)), REG_W'($urandom_range(10)));
						else
							set_config(REG_W'($urandom_range(10)), REG_W'($urandom_range(10)));
					end
				endcase
			end

			// history before the trigger; the long post count runs past the ring depth
			n_pre = int'($urandom_range(12));
			repeat (n_pre) begin
				maybe_noise(MODE_ARMED);
				send_sample();
			end
			send_item(KIND_TRIGGER, rand_sample(), rand_sample());
			repeat ((cur_post == 0) ? 1 : cur_post) begin
				maybe_noise(MODE_CAPTURE);
				send_sample();
			end

			wl = window_words(cur_pre, cur_post);
			if (ep == 2 || ep == 3)
				cut = int'($urandom_range(1, 8));
			else if (wl > 1 && $urandom_range(5) == 0)
				cut = int'($urandom_range(1, wl - 1));
			else
				cut = wl;
			repeat (cut) begin
				maybe_noise(MODE_READOUT);
				send_item(KIND_READ, rand_sample(), rand_sample());
			end
			if (cut < wl) begin
				// shrink the window to no more than the words already read: next read ends it
				drain();
				set_config(REG_W'($urandom_range(cut - 1)), REG_W'($urandom_range(1)));
				send_item(KIND_READ, '0, '0);
			end
			ep++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (outstanding != 0)
			$display("%0d read results never arrived", outstanding);
		$display("Run covered %0d items in %0d capture cycles, %0d full windows, %0d words",
			sent_items, ep + 1, windows_done, words_checked);
		$display("(%0d of them before capture ended), pre/post settings from 0 to 255",
			early_reads);
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
hdl/pcr_pkg.sv
hdl/pcr_ring.sv
hdl/pretrigger_capture_ring.sv
tb/pretrigger_capture_ring_checker.sv
tb/pretrigger_capture_ring_tb.sv
